/* src/sha256_message_hasher_macros.svh */
// ----------------------------------------------------------------------------
// SHA-256 message hasher assertion macros
// Shorthand for clocked, reset-qualified properties in the hasher RTL.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_HASHER_MACROS_SVH
`define SHA256_MESSAGE_HASHER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define SHAMH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define SHAMH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/shamh_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 message hasher package
// Round constants, initial hash values and the round control bundle.
// ----------------------------------------------------------------------------
package shamh_pkg;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [3:0] LEN_HI_IDX = 4'd14;
    localparam logic [3:0] LAST_WIDX  = 4'd15;

    typedef struct packed {
        logic shift;   // shift working vars toward a, new value into h
        logic round;   // run one compression round
        logic cap;     // capture w[t-16] and w[t-15] from the window memory
        logic expand;  // form the expanded schedule word
        logic use_q;   // round takes its word straight from the window memory
    } t_round_ctl;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] idx);
        logic [31:0] h;
        unique case (idx)
            3'd0: h = 32'h6a09e667;
            3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;
            3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;
            3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            3'd7: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

endpackage

/* src/shamh_wmem.sv */
// ----------------------------------------------------------------------------
// SHA-256 schedule window memory
// 16 x 32-bit message/schedule words, one write port, two registered reads.
// ----------------------------------------------------------------------------
module shamh_wmem import shamh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rd_en,
    input  logic [3:0]  i_rd_addr0,
    input  logic [3:0]  i_rd_addr1,
    output logic [31:0] o_rd_data0,
    output logic [31:0] o_rd_data1,
    input  logic        i_wr_en,
    input  logic [3:0]  i_wr_addr,
    input  logic [31:0] i_wr_data
);

    logic [31:0] r_mem [16];
    logic [31:0] r_q0;
    logic [31:0] r_q1;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q0 <= r_mem[i_rd_addr0];
            r_q1 <= r_mem[i_rd_addr1];
        end
    end

    assign o_rd_data0 = r_q0;
    assign o_rd_data1 = r_q1;

endmodule

/* src/shamh_hmem.sv */
// ----------------------------------------------------------------------------
// SHA-256 chaining value memory
// 8 x 32-bit hash words; an entry not written since the last clear reads
// as its initial hash value.
// ----------------------------------------------------------------------------
module shamh_hmem import shamh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_clr,
    input  logic        i_rd_en,
    input  logic [2:0]  i_rd_addr,
    output logic [31:0] o_rd_data,
    input  logic        i_wr_en,
    input  logic [2:0]  i_wr_addr,
    input  logic [31:0] i_wr_data
);

    logic [31:0] r_mem [8];
    logic [7:0]  r_valid;
    logic [31:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_clr) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : init_h(i_rd_addr);
        end
    end

    assign o_rd_data = r_q;

endmodule

/* src/shamh_round.sv */
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Working variables a..h, one compression round per step, and the
// schedule expansion from words read out of the window memory.
// ----------------------------------------------------------------------------
module shamh_round import shamh_pkg::*; (
    input  logic        i_clk,
    input  t_round_ctl  i_ctl,
    input  logic [31:0] i_shift_data,
    input  logic [31:0] i_k,
    input  logic [31:0] i_q0,
    input  logic [31:0] i_q1,
    output logic [31:0] o_wexp,
    output logic [31:0] o_a
);

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    logic [31:0] r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [31:0] r_w16;
    logic [31:0] r_w15;
    logic [31:0] r_w;
    logic [31:0] w_word;
    logic [31:0] w_t1;
    logic [31:0] w_t2;

    assign w_word = i_ctl.use_q ? i_q0 : r_w;
    assign w_t1   = r_h + bsig1(r_e) + ((r_e & r_f) ^ (~r_e & r_g)) + i_k + w_word;
    assign w_t2   = bsig0(r_a) + ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));
    // i_q0 carries w[t-7] and i_q1 carries w[t-2] on the expand step
    assign o_wexp = r_w16 + ssig0(r_w15) + i_q0 + ssig1(i_q1);
    assign o_a    = r_a;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_a <= r_b;
            r_b <= r_c;
            r_c <= r_d;
            r_d <= r_e;
            r_e <= r_f;
            r_f <= r_g;
            r_g <= r_h;
            r_h <= i_shift_data;
        end else if (i_ctl.round) begin
            r_h <= r_g;
            r_g <= r_f;
            r_f <= r_e;
            r_e <= r_d + w_t1;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= r_a;
            r_a <= w_t1 + w_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_w16 <= i_q0;
            r_w15 <= i_q1;
        end
        if (i_ctl.expand) begin
            r_w <= o_wexp;
        end
    end

endmodule

/* src/sha256_message_hasher.sv */
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Byte-wide message in, 256-bit digest out as eight 32-bit words.
//
//   channel  handshake                  payload
//   input    i_in_valid / o_in_ready    i_data_byte, i_has_byte, i_end_of_message
//   output   o_out_valid / i_out_ready  o_digest_word, o_word_index, o_last_word
//
// Byte items are taken back to back in the idle state. The item that fills a
// 64-byte block starts a compression (load the chaining words, 16 rounds that
// take their words straight from the window memory, 48 rounds paced by the two
// read ports of the window memory as they expand the schedule, then fold back)
// during which no item is taken. An end item writes the padding words of each
// padded block, runs one or two compressions, then reads out the digest words.
// Reset clears the valid bits of the chaining memory, so it reads as the
// initial hash values at once. A stalled output holds the digest sequencer.
// ----------------------------------------------------------------------------
`include "sha256_message_hasher_macros.svh"

module sha256_message_hasher import shamh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_LOAD  = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_FIN   = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    logic [63:0] r_count, n_count;
    logic [3:0]  r_widx, n_widx;
    logic        r_fit, n_fit;
    logic        r_mark_done, n_mark_done;
    logic        r_eom, n_eom;
    logic        r_final, n_final;
    logic [3:0]  r_cnt, n_cnt;
    logic [5:0]  r_t, n_t;
    logic [1:0]  r_sub, n_sub;
    logic [2:0]  r_oidx, n_oidx;
    logic        r_osub, n_osub;
    logic        r_out_valid, n_out_valid;

    logic [23:0] r_pack;
    logic [31:0] r_digest;
    logic [2:0]  r_index;
    logic        r_last;

    logic        w_acc;
    logic [5:0]  w_pos;
    logic [5:0]  w_pos_new;
    logic        w_blk_full;
    logic        w_early;
    logic        w_out_load;
    logic [3:0]  w_cnt_m1;
    logic [31:0] w_marker;
    logic [31:0] w_pad_word;

    logic        w_w_rd_en;
    logic [3:0]  w_w_rd_addr0;
    logic [3:0]  w_w_rd_addr1;
    logic [31:0] w_w_q0;
    logic [31:0] w_w_q1;
    logic        w_w_wr_en;
    logic [3:0]  w_w_wr_addr;
    logic [31:0] w_w_wr_data;

    logic        w_h_clr;
    logic        w_h_rd_en;
    logic [2:0]  w_h_rd_addr;
    logic [31:0] w_h_q;
    logic        w_h_wr_en;
    logic [31:0] w_h_wr_data;

    t_round_ctl  w_rctl;
    logic [31:0] w_wexp;
    logic [31:0] w_a;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_pos      = r_count[8:3];
    assign w_pos_new  = i_has_byte ? (w_pos + 6'd1) : w_pos;
    assign w_blk_full = i_has_byte && (w_pos == 6'd63);
    assign w_early    = (r_t[5:4] == 2'b00);
    assign w_cnt_m1   = r_cnt - 4'd1;
    assign w_out_load = (r_state == ST_OUT) && r_osub && (!r_out_valid || i_out_ready);

    // Word holding the pad marker after the bytes already packed
    always_comb begin
        unique case (r_count[4:3])
            2'd0: w_marker = {PAD_MARK, 24'h0};
            2'd1: w_marker = {r_pack[7:0], PAD_MARK, 16'h0};
            2'd2: w_marker = {r_pack[15:0], PAD_MARK, 8'h0};
            2'd3: w_marker = {r_pack[23:0], PAD_MARK};
        endcase
    end

    always_comb begin
        if (!r_mark_done) begin
            w_pad_word = w_marker;
        end else if (r_fit && (r_widx >= LEN_HI_IDX)) begin
            w_pad_word = r_widx[0] ? r_count[31:0] : r_count[63:32];
        end else begin
            w_pad_word = '0;
        end
    end

    // Window memory port control
    always_comb begin
        w_w_wr_en    = 1'b0;
        w_w_wr_addr  = r_widx;
        w_w_wr_data  = w_pad_word;
        w_w_rd_en    = 1'b0;
        w_w_rd_addr0 = r_t[3:0];
        w_w_rd_addr1 = r_t[3:0] + 4'd1;
        if (w_acc && i_has_byte && (w_pos[1:0] == 2'd3)) begin
            w_w_wr_en   = 1'b1;
            w_w_wr_addr = w_pos[5:2];
            w_w_wr_data = {r_pack, i_data_byte};
        end else if (r_state == ST_PAD) begin
            w_w_wr_en = 1'b1;
        end else if ((r_state == ST_ROUND) && (r_sub == 2'd2)) begin
            w_w_wr_en   = 1'b1;
            w_w_wr_addr = r_t[3:0];
            w_w_wr_data = w_wexp;
        end
        if (r_state == ST_ROUND) begin
            if (r_sub == 2'd0) begin
                w_w_rd_en = 1'b1;
            end else if ((r_sub == 2'd1) && !w_early) begin
                // fetch w[t-7] and w[t-2]
                w_w_rd_en    = 1'b1;
                w_w_rd_addr0 = r_t[3:0] + 4'd9;
                w_w_rd_addr1 = r_t[3:0] + 4'd14;
            end
        end
    end

    // Chaining memory port control
    assign w_h_rd_en   = (((r_state == ST_LOAD) || (r_state == ST_FIN)) && !r_cnt[3])
                         || ((r_state == ST_OUT) && !r_osub);
    assign w_h_rd_addr = (r_state == ST_OUT) ? r_oidx : r_cnt[2:0];
    assign w_h_wr_en   = (r_state == ST_FIN) && (r_cnt != 4'd0);
    assign w_h_wr_data = w_h_q + w_a;
    assign w_h_clr     = w_out_load && (r_oidx == 3'd7);

    always_comb begin
        w_rctl.shift  = ((r_state == ST_LOAD) || (r_state == ST_FIN)) && (r_cnt != 4'd0);
        w_rctl.round  = (r_state == ST_ROUND)
                        && (((r_sub == 2'd1) && w_early) || (r_sub == 2'd3));
        w_rctl.use_q  = (r_sub == 2'd1);
        w_rctl.cap    = (r_state == ST_ROUND) && (r_sub == 2'd1) && !w_early;
        w_rctl.expand = (r_state == ST_ROUND) && (r_sub == 2'd2);
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_widx      = r_widx;
        n_fit       = r_fit;
        n_mark_done = r_mark_done;
        n_eom       = r_eom;
        n_final     = r_final;
        n_cnt       = r_cnt;
        n_t         = r_t;
        n_sub       = r_sub;
        n_oidx      = r_oidx;
        n_osub      = r_osub;
        n_out_valid = w_out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_mark_done = 1'b0;
                    n_eom       = i_end_of_message;
                    n_final     = 1'b0;
                    if (i_has_byte) begin
                        n_count = r_count + 64'd8;
                    end
                    if (w_blk_full) begin
                        n_state = ST_LOAD;
                        n_cnt   = '0;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                        n_widx  = w_pos_new[5:2];
                        n_fit   = (w_pos_new < 6'd56);
                    end
                end
            end
            ST_PAD: begin
                n_mark_done = 1'b1;
                if (r_widx == LAST_WIDX) begin
                    n_final = r_fit && r_mark_done;
                    n_state = ST_LOAD;
                    n_cnt   = '0;
                end else begin
                    n_widx = r_widx + 4'd1;
                end
            end
            ST_LOAD: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt[3]) begin
                    n_state = ST_ROUND;
                    n_t     = '0;
                    n_sub   = '0;
                end
            end
            ST_ROUND: begin
                if (w_rctl.round) begin
                    n_sub = '0;
                    if (r_t == 6'd63) begin
                        n_state = ST_FIN;
                        n_cnt   = '0;
                    end else begin
                        n_t = r_t + 6'd1;
                    end
                end else begin
                    n_sub = r_sub + 2'd1;
                end
            end
            ST_FIN: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt[3]) begin
                    if (r_final) begin
                        n_state = ST_OUT;
                        n_oidx  = '0;
                        n_osub  = 1'b0;
                    end else if (r_eom) begin
                        // next padding block: the marker if not yet written, zeros, then the length
                        n_state = ST_PAD;
                        n_widx  = '0;
                        n_fit   = 1'b1;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                if (!r_osub) begin
                    n_osub = 1'b1;
                end else if (w_out_load) begin
                    n_osub = 1'b0;
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        n_state = ST_IDLE;
                        n_count = '0;
                        n_eom   = 1'b0;
                        n_final = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_widx      <= '0;
            r_fit       <= 1'b0;
            r_mark_done <= 1'b0;
            r_eom       <= 1'b0;
            r_final     <= 1'b0;
            r_cnt       <= '0;
            r_t         <= '0;
            r_sub       <= '0;
            r_oidx      <= '0;
            r_osub      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_widx      <= n_widx;
            r_fit       <= n_fit;
            r_mark_done <= n_mark_done;
            r_eom       <= n_eom;
            r_final     <= n_final;
            r_cnt       <= n_cnt;
            r_t         <= n_t;
            r_sub       <= n_sub;
            r_oidx      <= n_oidx;
            r_osub      <= n_osub;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_has_byte) begin
            r_pack <= {r_pack[15:0], i_data_byte};
        end
        if (w_out_load) begin
            r_digest <= w_h_q;
            r_index  <= r_oidx;
            r_last   <= (r_oidx == 3'd7);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_digest_word = r_digest;
    assign o_word_index  = r_index;
    assign o_last_word   = r_last;

    shamh_wmem u_wmem (
        .i_clk      (i_clk),
        .i_rd_en    (w_w_rd_en),
        .i_rd_addr0 (w_w_rd_addr0),
        .i_rd_addr1 (w_w_rd_addr1),
        .o_rd_data0 (w_w_q0),
        .o_rd_data1 (w_w_q1),
        .i_wr_en    (w_w_wr_en),
        .i_wr_addr  (w_w_wr_addr),
        .i_wr_data  (w_w_wr_data)
    );

    shamh_hmem u_hmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (w_h_clr),
        .i_rd_en   (w_h_rd_en),
        .i_rd_addr (w_h_rd_addr),
        .o_rd_data (w_h_q),
        .i_wr_en   (w_h_wr_en),
        .i_wr_addr (w_cnt_m1[2:0]),
        .i_wr_data (w_h_wr_data)
    );

    shamh_round u_round (
        .i_clk        (i_clk),
        .i_ctl        (w_rctl),
        .i_shift_data (w_h_q),
        .i_k          (round_k(r_t)),
        .i_q0         (w_w_q0),
        .i_q1         (w_w_q1),
        .o_wexp       (w_wexp),
        .o_a          (w_a)
    );

    `SHAMH_ASSERT_NOW(a_chain_wr_in_fold, w_h_wr_en, r_state == ST_FIN, "chain written outside fold")
    `SHAMH_ASSERT_NOW(a_early_round_short, (r_state == ST_ROUND) && w_early, r_sub <= 2'd1, "early round ran long")
    `SHAMH_ASSERT_NEXT(a_end_holds_input, w_acc && i_end_of_message, !o_in_ready, "input taken during digest")
    `SHAMH_ASSERT_NOW(a_win_rd_wr_split, w_w_rd_en && w_w_wr_en, w_acc == 1'b0, "window read during byte write")

endmodule

/* test/sha256_message_hasher_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Streams byte messages into the hasher with random valid and ready gaps,
// predicts each digest with a software SHA-256 and checks every digest word,
// its index and its last flag in order.
// ----------------------------------------------------------------------------
package sha256_hasher_tb_pkg;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_word_t;

    class digest_scoreboard;
        logic [31:0]  chain [8];
        logic [7:0]   blk [64];
        logic [63:0]  bit_count;
        digest_word_t pending_words [$];
        int unsigned  errors;
        int unsigned  words_checked;
        int unsigned  messages;
        int unsigned  bytes_hashed;
        int unsigned  blocks_hashed;

        function new();
            errors        = 0;
            words_checked = 0;
            messages      = 0;
            bytes_hashed  = 0;
            blocks_hashed = 0;
            for (int i = 0; i < 64; i++) blk[i] = 8'h00;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++) chain[i] = HASH_IV[i];
            bit_count = '0;
        endfunction

        static function logic [31:0] rotr(logic [31:0] x, int unsigned n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] t1;
            logic [31:0] t2;
            logic [31:0] s0;
            logic [31:0] s1;
            for (int i = 0; i < 16; i++) begin
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            end
            for (int i = 16; i < 64; i++) begin
                s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = w[i-16] + s0 + w[i-7] + s1;
            end
            for (int i = 0; i < 8; i++) v[i] = chain[i];
            for (int i = 0; i < 64; i++) begin
                t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
                t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
            blocks_hashed++;
        endfunction

        // Absorb one accepted item; an end item queues the eight digest words
        function void note_item(logic [7:0] data, logic has, logic eom);
            logic [5:0]   pos;
            int unsigned  p;
            digest_word_t dw;
            pos = bit_count[8:3];
            if (has) begin
                blk[pos]  = data;
                bit_count = bit_count + 64'd8;
                bytes_hashed++;
                pos = pos + 6'd1;
                if (pos == 6'd0) compress();
            end
            if (!eom) return;
            p      = pos;
            blk[p] = PAD_BYTE;
            p++;
            // no room left for the length: finish this block with zeros first
            if (p > 56) begin
                while (p < 64) begin
                    blk[p] = 8'h00;
                    p++;
                end
                compress();
                p = 0;
            end
            while (p < 56) begin
                blk[p] = 8'h00;
                p++;
            end
            for (int i = 0; i < 8; i++) blk[56+i] = bit_count[63-8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++) begin
                dw.word = chain[i];
                dw.idx  = 3'(i);
                dw.last = (i == 7);
                pending_words = {pending_words, dw};
            end
            messages++;
            restart();
        endfunction

        function void check_word(logic [31:0] word, logic [2:0] idx, logic last);
            digest_word_t dw;
            if (pending_words.size() == 0) begin
                $display("%0t: digest word %h (index %0d) with none expected",
                         $time, word, idx);
                errors++;
                return;
            end
            dw = pending_words.pop_front();
            words_checked++;
            if (word !== dw.word) begin
                $display("%0t: digest_word mismatch: expected %h actual %h",
                         $time, dw.word, word);
                errors++;
            end
            if (idx !== dw.idx) begin
                $display("%0t: word_index mismatch: expected %0d actual %0d",
                         $time, dw.idx, idx);
                errors++;
            end
            if (last !== dw.last) begin
                $display("%0t: last_word mismatch: expected %b actual %b",
                         $time, dw.last, last);
                errors++;
            end
        endfunction

        function int unsigned words_left();
            return pending_words.size();
        endfunction
    endclass

endpackage

module sha256_message_hasher_tb;
    import sha256_hasher_tb_pkg::*;

    localparam int unsigned LONG_HOLD      = 800;
    localparam int unsigned TAIL_CYCLES    = 600;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned BOUNDARY_LEN [7] = '{54, 55, 56, 57, 63, 64, 65};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_has_byte;
    logic        i_end_of_message;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    digest_scoreboard sb;
    bit          idle_on;
    bit          calm;
    bit          stall_req;
    int unsigned items_sent;
    int unsigned long_holds;
    int unsigned drain_pauses;

    sha256_message_hasher dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_has_byte      (i_has_byte),
        .i_end_of_message(i_end_of_message),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_digest_word   (o_digest_word),
        .o_word_index    (o_word_index),
        .o_last_word     (o_last_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one item, after an optional idle burst, and hold it until taken
    task automatic offer_item(input logic [7:0] data, input logic has, input logic eom);
        int unsigned gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid       <= 1'b1;
        i_data_byte      <= data;
        i_has_byte       <= has;
        i_end_of_message <= eom;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_item(data, has, eom);
        items_sent++;
    endtask

    task automatic send_message(input int unsigned len);
        bit end_has_byte;
        end_has_byte = (len != 0) && ($urandom_range(0, 1) == 1);
        idle_on      = !calm && ($urandom_range(0, 3) != 0);
        for (int unsigned n = 0; n < len; n++) begin
            // drop in an empty item now and then
            if (!calm && $urandom_range(0, 7) == 0) begin
                offer_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            offer_item(8'($urandom_range(0, 255)), 1'b1,
                       end_has_byte && (n == len - 1));
        end
        if (!end_has_byte) offer_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Drop the last item before waiting so it is not taken twice
    task automatic wait_digests_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.words_left() != 0) @(posedge i_clk);
    endtask

    function automatic int unsigned pick_length();
        if ($urandom_range(0, 9) == 0) return BOUNDARY_LEN[$urandom_range(0, 6)];
        return $urandom_range(0, 12);
    endfunction

    // Digest reader: random ready bursts, plus a long hold-off on request
    initial begin
        int unsigned idle_left;
        int unsigned hold_left;
        idle_left   = 0;
        hold_left   = 0;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall_req) begin
                stall_req = 1'b0;
                hold_left = LONG_HOLD;
                long_holds++;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (idle_left != 0) begin
                idle_left--;
                i_out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                idle_left = $urandom_range(1, 3) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready) begin
                sb.check_word(o_digest_word, o_word_index, o_last_word);
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: timeout, no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        bit paused;
        sb               = new();
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_data_byte      = 8'h00;
        i_has_byte       = 1'b0;
        i_end_of_message = 1'b0;
        idle_on          = 1'b0;
        calm             = 1'b0;
        stall_req        = 1'b0;
        items_sent       = 0;
        long_holds       = 0;
        drain_pauses     = 0;
        paused           = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty message, byte field set but ignored
        offer_item(8'hff, 1'b0, 1'b1);
        // extremes, an ignored byte mid-message, last byte on the end item
        offer_item(8'h00, 1'b1, 1'b0);
        offer_item(8'ha5, 1'b0, 1'b0);
        offer_item(8'hff, 1'b1, 1'b0);
        offer_item(8'h80, 1'b1, 1'b1);
        // "abc", closed by an empty end item
        offer_item(8'h61, 1'b1, 1'b0);
        offer_item(8'h62, 1'b1, 1'b0);
        offer_item(8'h63, 1'b1, 1'b0);
        offer_item(8'h00, 1'b0, 1'b1);
        // two empty messages back to back
        offer_item(8'h00, 1'b0, 1'b1);
        offer_item(8'h5a, 1'b0, 1'b1);
        wait_digests_drained();
        drain_pauses++;

        // padding fits in the last block, then spills into a second one
        send_message(55);
        send_message(56);

        // hold the reader off and keep feeding until the input stalls
        stall_req = 1'b1;
        send_message(5);
        send_message(8);
        send_message(6);
        wait_digests_drained();
        drain_pauses++;

        while (items_sent < 160) begin
            if (!paused && items_sent >= 130) begin
                wait_digests_drained();
                drain_pauses++;
                paused = 1'b1;
            end
            send_message(pick_length());
        end

        calm    = 1'b1;
        idle_on = 1'b0;
        while (items_sent < 175) send_message($urandom_range(0, 12));
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        wait_digests_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Hashed %0d messages, %0d bytes in %0d blocks; %0d digest words checked",
                 sb.messages, sb.bytes_hashed, sb.blocks_hashed, sb.words_checked);
        $display("Reader hold-offs: %0d, drain pauses: %0d, leftover words: %0d",
                 long_holds, drain_pauses, sb.words_left());
        if (sb.errors == 0 && sb.words_left() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
